// ===== hw/rtl/spq_pkg.sv =====
// Shared types, codes and constants for the sorted priority queue.
package spq_pkg;

    // Default number of storage entries
    localparam int DEFAULT_CAPACITY = 32;

    // Size register width and reset value
    localparam int          QSIZE_W     = 6;
    localparam logic [5:0]  QSIZE_RESET = 6'd32;

    // Field widths
    localparam int DATA_W  = 32;
    localparam int ENTRY_W = 2 * DATA_W;

    // Operation codes
    localparam logic KIND_ENQ = 1'b0;
    localparam logic KIND_DEQ = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENQ_LOOK,
        ST_ENQ_CMP,
        ST_DEQ
    } ctl_state_t;

    // Logical read address select
    typedef enum logic [1:0] {
        RD_HEAD,
        RD_POS_M1,
        RD_POS_M2
    } rd_sel_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_new;
        logic    wr_shift;
        logic    pos_dec;
        logic    push;
        logic    pop;
        logic    res_valid;
        status_t res_status;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic pos_zero;
        logic pos_one;
        logic less;
    } dp_stat_t;

endpackage

// ===== hw/rtl/sorted_priority_queue.sv =====
// Sorted priority queue top level: controller plus datapath.
// Refused enqueue (full) or dequeue (empty): done strobes in the cycle after start.
// Dequeue: start reads the head (one registered RAM read), then ST_DEQ pops it and sets done.
// Enqueue: ST_ENQ_LOOK reads the entry ahead of the hole; ST_ENQ_CMP moves entries with
// priority >= new one slot back, one entry per cycle, and then writes the new pair at the hole.
// busy drops with the done strobe, so the next command can start in that cycle; the
// receiver cannot stall. Reset clears the count and sets queue_size to 32; storage is kept.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     kind,
    input  logic signed [DATA_W-1:0] item_value,
    input  logic signed [DATA_W-1:0] item_priority,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] out_item,
    output logic signed [DATA_W-1:0] out_priority,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [QSIZE_W-1:0]       cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    spq_ctl u_ctl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    spq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .item_value    (item_value),
        .item_priority (item_priority),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .done          (done),
        .status        (status),
        .out_item      (out_item),
        .out_priority  (out_priority)
    );

endmodule

// ===== hw/rtl/spq_ram.sv =====
// Generic simple dual-port RAM with registered read.
module spq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port, hold when idle
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/spq_ctl.sv =====
// Controller state machine for the sorted priority queue.
module spq_ctl
    import spq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     kind,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start && kind == KIND_ENQ && !stat.full)
                begin
                    state_next = ST_ENQ_LOOK;
                end
                else if (start && kind == KIND_DEQ && !stat.empty)
                begin
                    state_next = ST_DEQ;
                end
            end
            ST_ENQ_LOOK:
            begin
                state_next = stat.pos_zero ? ST_IDLE : ST_ENQ_CMP;
            end
            ST_ENQ_CMP:
            begin
                if (stat.less)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.pos_one)
                begin
                    state_next = ST_ENQ_LOOK;
                end
            end
            ST_DEQ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd            = '0;
        cmd.rd_sel     = RD_HEAD;
        cmd.res_status = STATUS_DONE;
        busy           = (state_reg != ST_IDLE);
        case (state_reg)
            ST_IDLE:
            begin
                if (start && kind == KIND_ENQ)
                begin
                    if (stat.full)
                    begin
                        cmd.res_valid  = 1'b1;
                        cmd.res_status = STATUS_FULL;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
                else if (start)
                begin
                    if (stat.empty)
                    begin
                        cmd.res_valid  = 1'b1;
                        cmd.res_status = STATUS_EMPTY;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_HEAD;
                    end
                end
            end
            ST_ENQ_LOOK:
            begin
                // Place at the head slot, or fetch the entry below the hole
                if (stat.pos_zero)
                begin
                    cmd.wr_new    = 1'b1;
                    cmd.push      = 1'b1;
                    cmd.res_valid = 1'b1;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_POS_M1;
                end
            end
            ST_ENQ_CMP:
            begin
                // Drop the new pair into the hole, or advance the hole down
                if (stat.less)
                begin
                    cmd.wr_new    = 1'b1;
                    cmd.push      = 1'b1;
                    cmd.res_valid = 1'b1;
                end
                else
                begin
                    cmd.wr_shift = 1'b1;
                    cmd.pos_dec  = 1'b1;
                    if (!stat.pos_one)
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_POS_M2;
                    end
                end
            end
            ST_DEQ:
            begin
                cmd.pop       = 1'b1;
                cmd.res_valid = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== hw/rtl/spq_dp.sv =====
// Datapath of the sorted priority queue: ring storage, pointers, result registers.
module spq_dp
    import spq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    output dp_stat_t                 stat,
    input  logic signed [DATA_W-1:0] item_value,
    input  logic signed [DATA_W-1:0] item_priority,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [QSIZE_W-1:0]       cfg_data,
    output logic                     done,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] out_item,
    output logic signed [DATA_W-1:0] out_priority
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SW   = CW + 1;
    localparam int CMPW = (CW > QSIZE_W) ? CW : QSIZE_W;

    localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
    localparam logic [SW-1:0] CAP_S  = SW'(CAPACITY);
    localparam logic [IW-1:0] LAST_I = IW'(CAPACITY - 1);

    logic [QSIZE_W-1:0]       qsize_reg;
    logic [CW-1:0]            count_reg;
    logic [IW-1:0]            head_reg;
    logic [CW-1:0]            pos_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] prio_reg;
    logic                     res_valid_reg;
    status_t                  status_reg;
    logic signed [DATA_W-1:0] out_item_reg;
    logic signed [DATA_W-1:0] out_prio_reg;

    logic [CW-1:0]      rd_logical;
    logic [IW-1:0]      raddr;
    logic [IW-1:0]      waddr;
    logic               we;
    logic [ENTRY_W-1:0] wdata;
    logic [ENTRY_W-1:0] rdata;

    // Map a logical slot to a ring address
    function automatic logic [IW-1:0] phys_addr(input logic [IW-1:0] head,
                                                input logic [CW-1:0] slot);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(slot);
        if (sum >= CAP_S)
        begin
            sum = sum - CAP_S;
        end
        return sum[IW-1:0];
    endfunction

    // Size register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qsize_reg <= QSIZE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            qsize_reg <= cfg_data;
        end
    end

    // Status to controller
    always_comb
    begin
        stat.full     = (CMPW'(count_reg) >= CMPW'(qsize_reg)) || (count_reg == CAP_C);
        stat.empty    = (count_reg == '0);
        stat.pos_zero = (pos_reg == '0);
        stat.pos_one  = (pos_reg == CW'(1));
        stat.less     = $signed(rdata[ENTRY_W-1:DATA_W]) < prio_reg;
    end

    // Storage addressing
    always_comb
    begin
        case (cmd.rd_sel)
            RD_HEAD:   rd_logical = '0;
            RD_POS_M1: rd_logical = pos_reg - CW'(1);
            RD_POS_M2: rd_logical = pos_reg - CW'(2);
            default:   rd_logical = '0;
        endcase
    end

    assign raddr = phys_addr(head_reg, rd_logical);
    assign waddr = phys_addr(head_reg, pos_reg);
    assign we    = cmd.wr_new || cmd.wr_shift;
    assign wdata = cmd.wr_new ? {prio_reg, value_reg} : rdata;

    spq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Capture the enqueue transaction
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= item_value;
            prio_reg  <= item_priority;
        end
    end

    // Occupancy, head and hole pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                pos_reg <= count_reg;
            end
            else if (cmd.pos_dec)
            begin
                pos_reg <= pos_reg - CW'(1);
            end
            if (cmd.push)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.pop)
            begin
                count_reg <= count_reg - CW'(1);
                head_reg  <= (head_reg == LAST_I) ? '0 : head_reg + IW'(1);
            end
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= cmd.res_valid;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (cmd.res_valid)
        begin
            status_reg   <= cmd.res_status;
            out_item_reg <= cmd.pop ? $signed(rdata[DATA_W-1:0]) : '0;
            out_prio_reg <= cmd.pop ? $signed(rdata[ENTRY_W-1:DATA_W]) : '0;
        end
    end

    assign done         = res_valid_reg;
    assign status       = status_reg;
    assign out_item     = out_item_reg;
    assign out_priority = out_prio_reg;

    // Occupancy never exceeds storage
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("entry count above capacity");

    // A push adds exactly one entry
    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |=> count_reg == $past(count_reg) + CW'(1))
        else $error("push did not add one entry");

    // A pop only happens on a non-empty queue and removes one entry
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> count_reg != '0 ##1 count_reg == $past(count_reg) - CW'(1))
        else $error("pop on empty queue or bad count");

    // Refused transactions return zero payload
    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && status_reg != STATUS_DONE) |->
            (out_item_reg == '0 && out_prio_reg == '0))
        else $error("refused transaction carries payload");

endmodule
